[rtl/core/bcot_pkg.sv]
// ----------------------------------------------------------------------------
// bcot_pkg
// Shared widths, codes and types for the batch count / offset table.
// ----------------------------------------------------------------------------
package bcot_pkg;

  localparam int MAX_BATCHES = 64;
  localparam int IDX_W       = $clog2(MAX_BATCHES);
  localparam int USE_W       = $clog2(MAX_BATCHES + 1);
  localparam int CNT_W       = 16;
  localparam int KEY_W       = 32;
  localparam int FUNC_W      = 3;
  localparam int STAT_W      = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_REG    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ADD    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REM_ID = 3'd2;
  localparam logic [FUNC_W-1:0] FN_CREATE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REM_K  = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK   = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD  = 3'd1;
  localparam logic [STAT_W-1:0] ST_ZERO = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVF  = 3'd4;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_OUT
  } state_t;

  // Offset adjust for cells past the target
  typedef enum logic [1:0] {
    DL_NONE,
    DL_INC,
    DL_DEC
  } delta_t;

  // Update request broadcast to the cell row
  typedef struct packed {
    logic             upd;
    logic             append;
    logic [IDX_W-1:0] tgt;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] offset;
    delta_t           delta;
  } cell_cmd_t;

endpackage

[rtl/core/bcot_cell.sv]
// ----------------------------------------------------------------------------
// bcot_cell
// One table entry: key, count and offset, with key match and offset adjust.
// ----------------------------------------------------------------------------
module bcot_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [bcot_pkg::IDX_W-1:0] cell_idx,
  input  logic [bcot_pkg::USE_W-1:0] in_use,
  input  logic                       look_en,
  input  logic [bcot_pkg::KEY_W-1:0] look_key,
  input  bcot_pkg::cell_cmd_t        cmd,
  input  logic                       chain_in,
  output logic                       chain_out,
  output logic                       match,
  output logic [bcot_pkg::CNT_W-1:0] count,
  output logic [bcot_pkg::CNT_W-1:0] offset
);

  logic [bcot_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [bcot_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [bcot_pkg::CNT_W-1:0] offset_r, offset_nxt;
  logic                       match_r, match_nxt;
  logic                       sel;
  logic                       used;

  assign sel  = cmd.upd && (cmd.tgt == cell_idx);
  assign used = {1'b0, cell_idx} < in_use;

  // chain_in high means some earlier cell is the target
  assign chain_out = chain_in | sel;

  // next entry contents
  always_comb begin
    key_nxt    = key_r;
    count_nxt  = count_r;
    offset_nxt = offset_r;
    match_nxt  = match_r;
    if (look_en) begin
      match_nxt = used && (key_r == look_key);
    end
    if (sel) begin
      count_nxt = cmd.count;
      if (cmd.append) begin
        key_nxt    = cmd.key;
        offset_nxt = cmd.offset;
      end
    end else if (cmd.upd && chain_in) begin
      case (cmd.delta)
        bcot_pkg::DL_INC: offset_nxt = offset_r + 1'b1;
        bcot_pkg::DL_DEC: offset_nxt = offset_r - 1'b1;
        default:          offset_nxt = offset_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    count_r  <= count_nxt;
    offset_r <= offset_nxt;
  end

  assign match  = match_r;
  assign count  = count_r;
  assign offset = offset_r;

endmodule

[rtl/core/bcot_chain.sv]
// ----------------------------------------------------------------------------
// bcot_chain
// Row of table cells linked by the target-passed flag, plus hit encode/read.
// ----------------------------------------------------------------------------
module bcot_chain (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [bcot_pkg::USE_W-1:0] in_use,
  input  logic                       look_en,
  input  logic [bcot_pkg::KEY_W-1:0] look_key,
  input  bcot_pkg::cell_cmd_t        cmd,
  input  logic [bcot_pkg::IDX_W-1:0] rd_idx,
  output logic                       hit,
  output logic [bcot_pkg::IDX_W-1:0] hit_idx,
  output logic [bcot_pkg::CNT_W-1:0] rd_count,
  output logic [bcot_pkg::CNT_W-1:0] rd_offset
);

  logic [bcot_pkg::MAX_BATCHES:0]   link;
  logic [bcot_pkg::MAX_BATCHES-1:0] match;
  logic [bcot_pkg::CNT_W-1:0]       count_a  [bcot_pkg::MAX_BATCHES];
  logic [bcot_pkg::CNT_W-1:0]       offset_a [bcot_pkg::MAX_BATCHES];

  assign link[0] = 1'b0;

  // cell row
  for (genvar i = 0; i < bcot_pkg::MAX_BATCHES; i++) begin : g_cell
    bcot_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (bcot_pkg::IDX_W'(i)),
      .in_use    (in_use),
      .look_en   (look_en),
      .look_key  (look_key),
      .cmd       (cmd),
      .chain_in  (link[i]),
      .chain_out (link[i+1]),
      .match     (match[i]),
      .count     (count_a[i]),
      .offset    (offset_a[i])
    );
  end

  // keys are unique among used cells, so at most one match bit is set
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < bcot_pkg::MAX_BATCHES; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | bcot_pkg::IDX_W'(i);
      end
    end
  end

  assign hit       = |match;
  assign rd_count  = count_a[rd_idx];
  assign rd_offset = offset_a[rd_idx];

endmodule

[rtl/core/batch_count_offset_table_top.sv]
// A request passes through the sequencer states lookup, update and result
// (S_LOOK, S_EXEC, S_OUT); the result is held until taken on the output side.
// The block takes one request at a time through its lookup/update sequencer,
// and a stall on the result side holds off further requests.
// Reset: synchronous active-low rst_n empties the table and zeroes all totals;
// entry contents are not cleared, only the batches-in-use count.
// ----------------------------------------------------------------------------
// batch_count_offset_table_top
// Batch table with per-batch counts and prefix-sum offsets held in a cell row.
// ----------------------------------------------------------------------------
module batch_count_offset_table_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bcot_pkg::FUNC_W-1:0] in_func,
  input  logic [bcot_pkg::KEY_W-1:0]  in_key,
  input  logic [bcot_pkg::IDX_W-1:0]  in_batch_id,
  input  logic                        in_dynamic,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bcot_pkg::IDX_W-1:0]  out_result_batch,
  output logic [bcot_pkg::CNT_W-1:0]  out_first_instance,
  output logic [bcot_pkg::CNT_W-1:0]  out_instance_count,
  output logic [bcot_pkg::CNT_W-1:0]  out_total_count,
  output logic [bcot_pkg::CNT_W-1:0]  out_static_count,
  output logic [bcot_pkg::CNT_W-1:0]  out_dynamic_count,
  output logic [bcot_pkg::STAT_W-1:0] out_status
);

  bcot_pkg::state_t state_r, state_nxt;

  // request fields
  logic [bcot_pkg::FUNC_W-1:0] func_r;
  logic [bcot_pkg::KEY_W-1:0]  key_r;
  logic [bcot_pkg::IDX_W-1:0]  id_r;
  logic                        dyn_r;

  // totals
  logic [bcot_pkg::USE_W-1:0] in_use_r, in_use_nxt;
  logic [bcot_pkg::CNT_W-1:0] rt_r, rt_nxt;
  logic [bcot_pkg::CNT_W-1:0] st_r, st_nxt;
  logic [bcot_pkg::CNT_W-1:0] dt_r, dt_nxt;

  // lookup results
  logic [bcot_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       found_r, found_nxt;
  logic [bcot_pkg::CNT_W-1:0] cnt_sel_r;
  logic [bcot_pkg::CNT_W-1:0] off_sel_r;

  // result registers
  logic [bcot_pkg::IDX_W-1:0]  res_idx_r, res_idx_nxt;
  logic [bcot_pkg::CNT_W-1:0]  res_off_r, res_off_nxt;
  logic [bcot_pkg::CNT_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic [bcot_pkg::STAT_W-1:0] res_stat_r, res_stat_nxt;

  logic                       in_acc;
  logic                       by_key;
  logic                       has_batch;
  logic                       table_full;
  logic [bcot_pkg::CNT_W-1:0] cls;
  logic [bcot_pkg::CNT_W-1:0] cls_nxt;
  logic                       chain_hit;
  logic [bcot_pkg::IDX_W-1:0] chain_hit_idx;
  logic [bcot_pkg::CNT_W-1:0] chain_cnt;
  logic [bcot_pkg::CNT_W-1:0] chain_off;
  bcot_pkg::cell_cmd_t        cmd;

  assign in_acc     = in_valid && in_ready;
  assign cls        = dyn_r ? dt_r : st_r;
  assign table_full = (in_use_r == bcot_pkg::USE_W'(bcot_pkg::MAX_BATCHES));

  always_comb begin
    case (func_r)
      bcot_pkg::FN_REG, bcot_pkg::FN_CREATE, bcot_pkg::FN_REM_K: by_key = 1'b1;
      default:                                                   by_key = 1'b0;
    endcase
  end

  // cell row
  bcot_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_use    (in_use_r),
    .look_en   (in_acc),
    .look_key  (in_key),
    .cmd       (cmd),
    .rd_idx    (idx_nxt),
    .hit       (chain_hit),
    .hit_idx   (chain_hit_idx),
    .rd_count  (chain_cnt),
    .rd_offset (chain_off)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bcot_pkg::S_IDLE: if (in_valid) state_nxt = bcot_pkg::S_LOOK;
      bcot_pkg::S_LOOK: state_nxt = bcot_pkg::S_EXEC;
      bcot_pkg::S_EXEC: state_nxt = bcot_pkg::S_OUT;
      bcot_pkg::S_OUT:  if (out_ready) state_nxt = bcot_pkg::S_IDLE;
      default:          state_nxt = bcot_pkg::S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = (state_r == bcot_pkg::S_IDLE);
    out_valid = (state_r == bcot_pkg::S_OUT);
  end

  // lookup: pick batch by key match or by id
  always_comb begin
    if (by_key) begin
      idx_nxt   = chain_hit_idx;
      found_nxt = chain_hit;
    end else begin
      idx_nxt   = id_r;
      found_nxt = ({1'b0, id_r} < in_use_r);
    end
  end

  // update decision
  always_comb begin
    res_stat_nxt = bcot_pkg::ST_BAD;
    has_batch    = 1'b0;
    res_idx_nxt  = idx_r;
    res_off_nxt  = off_sel_r;
    res_cnt_nxt  = cnt_sel_r;
    in_use_nxt   = in_use_r;
    rt_nxt       = rt_r;
    cls_nxt      = cls;
    cmd          = '0;
    cmd.key      = key_r;
    cmd.delta    = bcot_pkg::DL_NONE;

    case (func_r)
      bcot_pkg::FN_REG, bcot_pkg::FN_CREATE: begin
        if (!found_r && table_full) begin
          res_stat_nxt = bcot_pkg::ST_FULL;
        end else if ((func_r == bcot_pkg::FN_CREATE) &&
                     ((rt_r == bcot_pkg::CNT_MAX) || (cls == bcot_pkg::CNT_MAX))) begin
          res_stat_nxt = bcot_pkg::ST_OVF;
          has_batch    = found_r;
        end else begin
          res_stat_nxt = bcot_pkg::ST_OK;
          has_batch    = 1'b1;
          if (!found_r) begin
            res_idx_nxt = in_use_r[bcot_pkg::IDX_W-1:0];
            res_off_nxt = rt_r;
            res_cnt_nxt = '0;
            cmd.append  = 1'b1;
            in_use_nxt  = in_use_r + 1'b1;
          end
          if (func_r == bcot_pkg::FN_CREATE) begin
            res_cnt_nxt = res_cnt_nxt + 1'b1;
            rt_nxt      = rt_r + 1'b1;
            cls_nxt     = cls + 1'b1;
            cmd.delta   = bcot_pkg::DL_INC;
          end
          cmd.upd    = 1'b1;
          cmd.tgt    = res_idx_nxt;
          cmd.count  = res_cnt_nxt;
          cmd.offset = res_off_nxt;
        end
      end
      bcot_pkg::FN_ADD: begin
        if (!found_r) begin
          res_stat_nxt = bcot_pkg::ST_BAD;
        end else if (rt_r == bcot_pkg::CNT_MAX) begin
          res_stat_nxt = bcot_pkg::ST_OVF;
          has_batch    = 1'b1;
        end else begin
          res_stat_nxt = bcot_pkg::ST_OK;
          has_batch    = 1'b1;
          res_cnt_nxt  = cnt_sel_r + 1'b1;
          rt_nxt       = rt_r + 1'b1;
          cmd.upd      = 1'b1;
          cmd.tgt      = idx_r;
          cmd.count    = res_cnt_nxt;
          cmd.delta    = bcot_pkg::DL_INC;
        end
      end
      bcot_pkg::FN_REM_ID, bcot_pkg::FN_REM_K: begin
        if (!found_r) begin
          res_stat_nxt = bcot_pkg::ST_BAD;
        end else if ((cnt_sel_r == '0) ||
                     ((func_r == bcot_pkg::FN_REM_K) && (cls == '0))) begin
          res_stat_nxt = bcot_pkg::ST_ZERO;
          has_batch    = 1'b1;
        end else begin
          res_stat_nxt = bcot_pkg::ST_OK;
          has_batch    = 1'b1;
          res_cnt_nxt  = cnt_sel_r - 1'b1;
          rt_nxt       = rt_r - 1'b1;
          if (func_r == bcot_pkg::FN_REM_K) begin
            cls_nxt = cls - 1'b1;
          end
          cmd.upd   = 1'b1;
          cmd.tgt   = idx_r;
          cmd.count = res_cnt_nxt;
          cmd.delta = bcot_pkg::DL_DEC;
        end
      end
      default: begin
        res_stat_nxt = bcot_pkg::ST_BAD;
      end
    endcase

    // failed lookups report no batch
    if (!has_batch) begin
      res_idx_nxt = '0;
      res_off_nxt = '0;
      res_cnt_nxt = '0;
    end

    // only apply while executing
    if (state_r != bcot_pkg::S_EXEC) begin
      cmd        = '0;
      cmd.delta  = bcot_pkg::DL_NONE;
      in_use_nxt = in_use_r;
      rt_nxt     = rt_r;
      cls_nxt    = cls;
    end

    st_nxt = dyn_r ? st_r : cls_nxt;
    dt_nxt = dyn_r ? cls_nxt : dt_r;
  end

  // control and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bcot_pkg::S_IDLE;
      in_use_r <= '0;
      rt_r     <= '0;
      st_r     <= '0;
      dt_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      in_use_r <= in_use_nxt;
      rt_r     <= rt_nxt;
      st_r     <= st_nxt;
      dt_r     <= dt_nxt;
    end
  end

  // request capture, lookup and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
      key_r  <= in_key;
      id_r   <= in_batch_id;
      dyn_r  <= in_dynamic;
    end
    if (state_r == bcot_pkg::S_LOOK) begin
      idx_r     <= idx_nxt;
      found_r   <= found_nxt;
      cnt_sel_r <= chain_cnt;
      off_sel_r <= chain_off;
    end
    if (state_r == bcot_pkg::S_EXEC) begin
      res_idx_r  <= res_idx_nxt;
      res_off_r  <= res_off_nxt;
      res_cnt_r  <= res_cnt_nxt;
      res_stat_r <= res_stat_nxt;
    end
  end

  assign out_result_batch   = res_idx_r;
  assign out_first_instance = res_off_r;
  assign out_instance_count = res_cnt_r;
  assign out_total_count    = rt_r;
  assign out_static_count   = st_r;
  assign out_dynamic_count  = dt_r;
  assign out_status         = res_stat_r;

endmodule

[rtl/core/bcot_chk.sv]
// ----------------------------------------------------------------------------
// bcot_chk
// Port-level checks for the batch table, bound to the top level.
// ----------------------------------------------------------------------------
module bcot_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [bcot_pkg::FUNC_W-1:0] in_func,
  input logic [bcot_pkg::KEY_W-1:0]  in_key,
  input logic [bcot_pkg::IDX_W-1:0]  in_batch_id,
  input logic                        in_dynamic,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bcot_pkg::IDX_W-1:0]  out_result_batch,
  input logic [bcot_pkg::CNT_W-1:0]  out_first_instance,
  input logic [bcot_pkg::CNT_W-1:0]  out_instance_count,
  input logic [bcot_pkg::CNT_W-1:0]  out_total_count,
  input logic [bcot_pkg::CNT_W-1:0]  out_static_count,
  input logic [bcot_pkg::CNT_W-1:0]  out_dynamic_count,
  input logic [bcot_pkg::STAT_W-1:0] out_status
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_result_batch) && $stable(out_total_count))
    else $error("result changed while stalled");

  // one request in flight: no intake while a result waits
  a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // fixed lookup/update latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##3 out_valid)
    else $error("result not valid three cycles after request");

  // failed lookup reports no batch
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == bcot_pkg::ST_BAD || out_status == bcot_pkg::ST_FULL) |->
      out_result_batch == '0 && out_first_instance == '0 && out_instance_count == '0)
    else $error("batch fields nonzero on lookup failure");

endmodule

bind batch_count_offset_table_top bcot_chk u_bcot_chk (.*);
